// ===== hw/rtl/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types and constants shared by the HSV to RGB and grey converter pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    // Hue value that wraps back to zero, and the width of one hue sector.
    localparam int unsigned HUE_WRAP   = 360;
    localparam int unsigned SECTOR_DEG = 60;

    // floor(h / 60) for h < 512 is (h * SECTOR_RECIP) >> SECTOR_SHIFT.
    localparam int unsigned SECTOR_RECIP = 1093;
    localparam int unsigned SECTOR_SHIFT = 16;

    // Full-scale level and the Q/T denominator (255 * 60).
    localparam int unsigned LEVEL_MAX = 255;
    localparam int unsigned FULL_DEN  = 15300;

    // x / 15300 is taken as (x >> 2) / 3825 with a rounded-up reciprocal.
    localparam int unsigned QT_DIV   = 3825;
    localparam int unsigned QT_SHIFT = 32;
    localparam longint unsigned QT_RECIP =
        ((64'd1 << QT_SHIFT) + QT_DIV - 1) / QT_DIV;

    // y / 255 for y < 65536 uses a rounded-up reciprocal as well.
    localparam int unsigned P_SHIFT = 24;
    localparam longint unsigned P_RECIP =
        ((64'd1 << P_SHIFT) + LEVEL_MAX - 1) / LEVEL_MAX;

    // Grey weights, summing to 64.
    localparam int unsigned GREY_WR = 21;
    localparam int unsigned GREY_WG = 32;
    localparam int unsigned GREY_WB = 11;

    // Hue sectors.
    localparam logic [3:0] SEC_RED_YEL = 4'd0;
    localparam logic [3:0] SEC_YEL_GRN = 4'd1;
    localparam logic [3:0] SEC_GRN_CYN = 4'd2;
    localparam logic [3:0] SEC_CYN_BLU = 4'd3;
    localparam logic [3:0] SEC_BLU_MAG = 4'd4;
    localparam logic [3:0] SEC_MAG_RED = 4'd5;
    localparam logic [3:0] SEC_LAST    = 4'd8;

    typedef struct packed {
        logic [8:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] grey_out;
    } pixel_out_t;

    typedef struct packed {
        logic [3:0] sector;
        logic [5:0] rem;
        logic [7:0] sat;
        logic [7:0] val;
        logic       sat_zero;
    } decoded_t;

    typedef struct packed {
        logic [3:0] sector;
        logic [7:0] val;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
        logic       sat_zero;
    } levels_t;

endpackage

// ===== hw/rtl/hsvrgb_decode.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_decode
// First pipeline stage: wraps hue 360 to 0 and splits hue into sector and
// remainder within the sector.
// ----------------------------------------------------------------------------
module hsvrgb_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  hsvrgb_pkg::pixel_in_t pix,
    output logic                  dec_valid,
    input  logic                  dec_ready,
    output hsvrgb_pkg::decoded_t  dec
);

    logic                 valid_reg;
    hsvrgb_pkg::decoded_t dec_reg;
    hsvrgb_pkg::decoded_t dec_next;
    logic [8:0]           hue_eff;
    logic [19:0]          recip_prod;
    logic [3:0]           sector;
    logic [8:0]           sector_base;

    assign hue_eff = (pix.hue == 9'(hsvrgb_pkg::HUE_WRAP)) ? 9'd0 : pix.hue;

    // The reciprocal is close enough that the floor is exact for every 9-bit hue.
    assign recip_prod  = 20'(hue_eff) * 20'(hsvrgb_pkg::SECTOR_RECIP);
    assign sector      = recip_prod[19:16];
    assign sector_base = 9'({5'd0, sector}) * 9'(hsvrgb_pkg::SECTOR_DEG);

    always_comb
    begin
        dec_next.sector   = sector;
        dec_next.rem      = 6'(hue_eff - sector_base);
        dec_next.sat      = pix.saturation;
        dec_next.val      = pix.brightness;
        dec_next.sat_zero = (pix.saturation == 8'd0);
    end

    assign pix_ready = !valid_reg || dec_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pix_ready)
        begin
            valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_ready && pix_valid)
        begin
            dec_reg <= dec_next;
        end
    end

    assign dec_valid = valid_reg;
    assign dec       = dec_reg;

endmodule

// ===== hw/rtl/hsvrgb_scale.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_scale
// Three pipeline stages that form the P, Q and T levels: numerators, then
// products with the value, then exact floor division by reciprocal multiply.
// ----------------------------------------------------------------------------
module hsvrgb_scale (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 dec_valid,
    output logic                 dec_ready,
    input  hsvrgb_pkg::decoded_t dec,
    output logic                 lvl_valid,
    input  logic                 lvl_ready,
    output hsvrgb_pkg::levels_t  lvl
);

    // Stage A: numerators.
    logic        a_valid_reg;
    logic        a_ready;
    logic [3:0]  a_sector_reg;
    logic [7:0]  a_val_reg;
    logic        a_sat_zero_reg;
    logic [7:0]  a_num_p_reg;
    logic [13:0] a_num_q_reg;
    logic [13:0] a_num_t_reg;
    logic [13:0] sat_rem;
    logic [13:0] sat_rest;

    // Stage B: products with the value.
    logic        b_valid_reg;
    logic        b_ready;
    logic [3:0]  b_sector_reg;
    logic [7:0]  b_val_reg;
    logic        b_sat_zero_reg;
    logic [15:0] b_prod_p_reg;
    logic [21:0] b_prod_q_reg;
    logic [21:0] b_prod_t_reg;

    // Stage C: floor division.
    logic                c_valid_reg;
    hsvrgb_pkg::levels_t c_lvl_reg;
    hsvrgb_pkg::levels_t c_lvl_next;
    logic [32:0]         div_p;
    logic [40:0]         div_q;
    logic [40:0]         div_t;

    assign sat_rem  = 14'(dec.sat) * 14'(dec.rem);
    assign sat_rest = 14'(dec.sat) * 14'(6'(hsvrgb_pkg::SECTOR_DEG) - dec.rem);

    assign dec_ready = !a_valid_reg || b_ready;
    assign b_ready   = !b_valid_reg || a_ready;
    assign a_ready   = !c_valid_reg || lvl_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (dec_ready)
            begin
                a_valid_reg <= dec_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (a_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_ready && dec_valid)
        begin
            a_sector_reg   <= dec.sector;
            a_val_reg      <= dec.val;
            a_sat_zero_reg <= dec.sat_zero;
            a_num_p_reg    <= 8'(hsvrgb_pkg::LEVEL_MAX) - dec.sat;
            a_num_q_reg    <= 14'(hsvrgb_pkg::FULL_DEN) - sat_rem;
            a_num_t_reg    <= 14'(hsvrgb_pkg::FULL_DEN) - sat_rest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_sector_reg   <= a_sector_reg;
            b_val_reg      <= a_val_reg;
            b_sat_zero_reg <= a_sat_zero_reg;
            b_prod_p_reg   <= 16'(a_val_reg) * 16'(a_num_p_reg);
            b_prod_q_reg   <= 22'(a_val_reg) * 22'(a_num_q_reg);
            b_prod_t_reg   <= 22'(a_val_reg) * 22'(a_num_t_reg);
        end
    end

    // Dropping the two low bits first leaves floor(x / 15300) unchanged.
    assign div_p = 33'(b_prod_p_reg) * 33'(hsvrgb_pkg::P_RECIP);
    assign div_q = 41'(b_prod_q_reg[21:2]) * 41'(hsvrgb_pkg::QT_RECIP);
    assign div_t = 41'(b_prod_t_reg[21:2]) * 41'(hsvrgb_pkg::QT_RECIP);

    always_comb
    begin
        c_lvl_next.sector   = b_sector_reg;
        c_lvl_next.val      = b_val_reg;
        c_lvl_next.p        = div_p[31:24];
        c_lvl_next.q        = div_q[39:32];
        c_lvl_next.t        = div_t[39:32];
        c_lvl_next.sat_zero = b_sat_zero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && b_valid_reg)
        begin
            c_lvl_reg <= c_lvl_next;
        end
    end

    assign lvl_valid = c_valid_reg;
    assign lvl       = c_lvl_reg;

endmodule

// ===== hw/rtl/hsvrgb_mix.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_mix
// Last pipeline stage: picks each channel from V, P, Q and T by sector and
// forms the weighted grey level. Its register is the output register.
// ----------------------------------------------------------------------------
module hsvrgb_mix (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   lvl_valid,
    output logic                   lvl_ready,
    input  hsvrgb_pkg::levels_t    lvl,
    output logic                   rgb_valid,
    input  logic                   rgb_ready,
    output hsvrgb_pkg::pixel_out_t rgb
);

    logic                   valid_reg;
    hsvrgb_pkg::pixel_out_t rgb_reg;
    hsvrgb_pkg::pixel_out_t rgb_next;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [13:0]            grey_sum;

    always_comb
    begin
        red   = 8'd0;
        green = 8'd0;
        blue  = 8'd0;
        if (lvl.sat_zero)
        begin
            red   = lvl.val;
            green = lvl.val;
            blue  = lvl.val;
        end
        else
        begin
            case (lvl.sector)
                hsvrgb_pkg::SEC_RED_YEL:
                begin
                    red = lvl.val; green = lvl.t; blue = lvl.p;
                end
                hsvrgb_pkg::SEC_YEL_GRN:
                begin
                    red = lvl.q; green = lvl.val; blue = lvl.p;
                end
                hsvrgb_pkg::SEC_GRN_CYN:
                begin
                    red = lvl.p; green = lvl.val; blue = lvl.t;
                end
                hsvrgb_pkg::SEC_CYN_BLU:
                begin
                    red = lvl.p; green = lvl.q; blue = lvl.val;
                end
                hsvrgb_pkg::SEC_BLU_MAG:
                begin
                    red = lvl.t; green = lvl.p; blue = lvl.val;
                end
                hsvrgb_pkg::SEC_MAG_RED:
                begin
                    red = lvl.val; green = lvl.p; blue = lvl.q;
                end
                // Hue past 360 with color present gives black.
                default:
                begin
                    red = 8'd0; green = 8'd0; blue = 8'd0;
                end
            endcase
        end
    end

    assign grey_sum = 14'(red) * 14'(hsvrgb_pkg::GREY_WR)
                    + 14'(green) * 14'(hsvrgb_pkg::GREY_WG)
                    + 14'(blue) * 14'(hsvrgb_pkg::GREY_WB);

    always_comb
    begin
        rgb_next.red_out   = red;
        rgb_next.green_out = green;
        rgb_next.blue_out  = blue;
        rgb_next.grey_out  = grey_sum[13:6];
    end

    assign lvl_ready = !valid_reg || rgb_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (lvl_ready)
        begin
            valid_reg <= lvl_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lvl_ready && lvl_valid)
        begin
            rgb_reg <= rgb_next;
        end
    end

    assign rgb_valid = valid_reg;
    assign rgb       = rgb_reg;

endmodule

// ===== hw/rtl/hsv_to_rgb_grey_converter.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_grey_converter
// Converts a stream of HSV pixels to RGB plus a weighted grey level.
// ----------------------------------------------------------------------------
// Usage:
// A pixel word (hue 0..511, saturation, brightness) enters on the pix channel
// and one result word (red, green, blue, grey) leaves on the rgb channel for
// each pixel, in order. Both channels use valid/ready.
// The pipeline has five register stages: decode, numerators, products,
// reciprocal divide, and channel select with grey. Throughput is one pixel
// per cycle while the output is not stalled; every stage holds its own valid
// bit and a new word is taken whenever the stage ahead is empty or moving.
// When the receiver holds rgb_ready low, the output word stays put and the
// stages fill up behind it; pix_ready falls only once all five are full.
// Reset empties the pipeline; no result is pending after reset.
// Saturation zero gives gray at the brightness level; hue 360 counts as 0;
// hue above 360 with nonzero saturation gives black.
// ----------------------------------------------------------------------------
module hsv_to_rgb_grey_converter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_ready,
    input  hsvrgb_pkg::pixel_in_t  pix,
    output logic                   rgb_valid,
    input  logic                   rgb_ready,
    output hsvrgb_pkg::pixel_out_t rgb
);

    logic                 dec_valid;
    logic                 dec_ready;
    hsvrgb_pkg::decoded_t dec;
    logic                 lvl_valid;
    logic                 lvl_ready;
    hsvrgb_pkg::levels_t  lvl;

    hsvrgb_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec)
    );

    hsvrgb_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec       (dec),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .lvl       (lvl)
    );

    hsvrgb_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .lvl       (lvl),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb)
    );

    // The sector split must stay within range for every hue.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid |-> (dec.sector <= hsvrgb_pkg::SEC_LAST) && (dec.rem < 6'd60))
    else $error("sector or remainder out of range");

    // Input back-pressure only when the whole pipeline is full and stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> (rgb_valid && !rgb_ready && lvl_valid && dec_valid))
    else $error("input stalled while the pipeline has room");

    // Grey is a weighted mean, so it cannot exceed every channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> (rgb.grey_out <= rgb.red_out) || (rgb.grey_out <= rgb.green_out)
                      || (rgb.grey_out <= rgb.blue_out))
    else $error("grey level above all channels");

endmodule
